>>> rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and codes for the countdown timer table
// Operation codes, result codes and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package ctt_pkg;

	// operation codes of an input transaction
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// result codes
	localparam logic [2:0] EV_STARTED = 3'd0;
	localparam logic [2:0] EV_FULL    = 3'd1;
	localparam logic [2:0] EV_CANCEL  = 3'd2;
	localparam logic [2:0] EV_FIRED   = 3'd3;
	localparam logic [2:0] EV_NONE    = 3'd4;

	// firing limit per tick and the width of its counter
	localparam int unsigned MAX_FIRES = 16;
	localparam int unsigned FIRE_W    = 5;

	// command word from the controller to the datapath
	typedef struct packed {
		logic load;       // latch operands, clear firing bookkeeping
		logic cancel;     // apply a cancel transaction now
		logic scan;       // start sweep: test slot at idx
		logic last_slot;  // idx is the highest slot
		logic rd;         // tick sweep: read count at idx
		logic proc;       // tick sweep: update slot at proc_idx
		logic flush;      // tick sweep done: emit the final result
	} cmd_t;

	// low four bits of a slot id for the result port
	function automatic logic [3:0] slot_low4(input logic [31:0] s);
		return s[3:0];
	endfunction

endpackage

>>> rtl/countdown_timer_table.sv
// ----------------------------------------------------------------------------
// countdown_timer_table: table of countdown timers
// Start claims the lowest free slot, cancel marks a slot, tick counts all
// active slots down and reports the slots that fire.
// ----------------------------------------------------------------------------
//
// channel   handshake                 payload
// -------   -----------------------   ------------------------------------------
// input     start high, busy low      operation duration timer_slot elapsed
//                                     blocked_mask
// result    strobe, one cycle         event_res slot last
//
// Cancel: result in the cycle after acceptance, busy stays low.
// Start: busy while sweeping for a free slot, one per cycle;
//   the result shows in the cycle after the sweep ends.
// Tick: busy through the sweep, the count update stage and the final result;
//   the final result is registered from the END state; each firing is held
//   until the next one is found, so firings come out in slot order.
// Reset clears all slot flags at once; counts have no reset and are first
//   written by start.
// The receiver cannot stall: each result is shown for a single cycle.
//
module countdown_timer_table #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [23:0] duration,
	input  logic [3:0]  timer_slot,
	input  logic [15:0] elapsed,
	input  logic [15:0] blocked_mask,
	output logic        strobe,
	output logic [2:0]  event_res,
	output logic [3:0]  slot,
	output logic        last
);

	localparam int unsigned SLOT_W = $clog2(NUM_TIMERS);

	ctt_pkg::cmd_t     cmd;
	logic [SLOT_W-1:0] idx;
	logic [SLOT_W-1:0] proc_idx;
	logic              slot_free;

	// sequencer
	ctt_ctrl #(
		.NUM_TIMERS (NUM_TIMERS),
		.SLOT_W     (SLOT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.slot_free (slot_free),
		.cmd       (cmd),
		.idx       (idx),
		.proc_idx  (proc_idx)
	);

	// datapath
	ctt_dp #(
		.NUM_TIMERS (NUM_TIMERS),
		.COUNT_BITS (COUNT_BITS),
		.SLOT_W     (SLOT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.proc_idx     (proc_idx),
		.slot_free    (slot_free),
		.duration     (duration),
		.timer_slot   (timer_slot),
		.elapsed      (elapsed),
		.blocked_mask (blocked_mask),
		.strobe       (strobe),
		.event_res    (event_res),
		.slot         (slot),
		.last         (last)
	);

endmodule

>>> rtl/ctt_ctrl.sv
// ----------------------------------------------------------------------------
// ctt_ctrl: sequencer of the countdown timer table
// Accepts transactions, walks the slot index for start and tick sweeps and
// drives the datapath through a command word.
// ----------------------------------------------------------------------------
module ctt_ctrl #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned SLOT_W     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        operation,
	input  logic              slot_free,
	output ctt_pkg::cmd_t     cmd,
	output logic [SLOT_W-1:0] idx,
	output logic [SLOT_W-1:0] proc_idx
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_TAIL = 3'd3;
	localparam logic [2:0] ST_END  = 3'd4;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_TIMERS - 1);

	logic [2:0]        state_q;
	logic [SLOT_W-1:0] idx_q;
	logic              proc_vld_s1;
	logic [SLOT_W-1:0] proc_idx_s1;
	logic              accept;
	logic              idx_last;

	assign accept   = start && (state_q == ST_IDLE);
	assign idx_last = (idx_q == LAST_IDX);
	assign busy     = (state_q != ST_IDLE);
	assign idx      = idx_q;
	assign proc_idx = proc_idx_s1;

	// command decode
	always_comb begin
		cmd.load      = accept;
		cmd.cancel    = accept && (operation == ctt_pkg::OP_CANCEL);
		cmd.scan      = (state_q == ST_SCAN);
		cmd.last_slot = idx_last;
		cmd.rd        = (state_q == ST_TICK);
		cmd.proc      = proc_vld_s1;
		cmd.flush     = (state_q == ST_END);
	end

	// state and slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (operation == ctt_pkg::OP_START)
							state_q <= ST_SCAN;
						else if (operation == ctt_pkg::OP_TICK)
							state_q <= ST_TICK;
					end
				end
				ST_SCAN: begin
					if (slot_free || idx_last)
						state_q <= ST_IDLE;
					else
						idx_q <= idx_q + SLOT_W'(1);
				end
				ST_TICK: begin
					if (idx_last)
						state_q <= ST_TAIL;
					else
						idx_q <= idx_q + SLOT_W'(1);
				end
				ST_TAIL: state_q <= ST_END;
				ST_END:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read-to-update stage of the tick sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_vld_s1 <= 1'b0;
		end else begin
			proc_vld_s1 <= (state_q == ST_TICK);
		end
	end

	always_ff @(posedge clk) begin
		proc_idx_s1 <= idx_q;
	end

endmodule

>>> rtl/ctt_dp.sv
// ----------------------------------------------------------------------------
// ctt_dp: datapath of the countdown timer table
// Count memory, active and cancel flags, the held firing and the result
// registers.
// ----------------------------------------------------------------------------
module ctt_dp #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned COUNT_BITS = 24,
	parameter int unsigned SLOT_W     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctt_pkg::cmd_t     cmd,
	input  logic [SLOT_W-1:0] idx,
	input  logic [SLOT_W-1:0] proc_idx,
	output logic              slot_free,
	input  logic [23:0]       duration,
	input  logic [3:0]        timer_slot,
	input  logic [15:0]       elapsed,
	input  logic [15:0]       blocked_mask,
	output logic              strobe,
	output logic [2:0]        event_res,
	output logic [3:0]        slot,
	output logic              last
);

	localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	logic [COUNT_BITS-1:0]      remaining_ms [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]      active_q;
	logic [NUM_TIMERS-1:0]      pending_q;
	logic [COUNT_BITS-1:0]      dur_q;
	logic [15:0]                el_q;
	logic [15:0]                blk_q;
	logic [COUNT_BITS-1:0]      rdata_s1;
	logic                       hold_vld_q;
	logic [SLOT_W-1:0]          hold_slot_q;
	logic [ctt_pkg::FIRE_W-1:0] fire_cnt_q;
	logic                       strobe_q;
	logic [2:0]                 event_q;
	logic [3:0]                 slot_q;
	logic                       last_q;

	logic [31:0]           dur_ext;
	logic [31:0]           dur_sat;
	logic [31:0]           sel_ext;
	logic                  sel_ok;
	logic [SLOT_W-1:0]     sel_i;
	logic [31:0]           cnt_ext;
	logic [31:0]           el_ext;
	logic [31:0]           diff;
	logic [COUNT_BITS-1:0] r_new;
	logic [31:0]           p_ext;
	logic                  p_act;
	logic                  p_pend;
	logic                  p_blocked;
	logic                  fire;
	logic                  mem_we;
	logic [SLOT_W-1:0]     mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;

	// duration clamp to the count range
	assign dur_ext = 32'(duration);
	assign dur_sat = (dur_ext > CMAX) ? CMAX : dur_ext;

	// cancel target
	assign sel_ext = 32'(timer_slot);
	assign sel_ok  = (sel_ext < 32'(NUM_TIMERS));
	assign sel_i   = sel_ext[SLOT_W-1:0];

	assign slot_free = !active_q[idx];

	// saturating count-down of the slot under update
	assign cnt_ext = 32'(rdata_s1);
	assign el_ext  = 32'(el_q);
	assign diff    = (cnt_ext > el_ext) ? (cnt_ext - el_ext) : 32'd0;
	assign r_new   = diff[COUNT_BITS-1:0];

	// firing decision
	assign p_ext     = 32'(proc_idx);
	assign p_act     = active_q[proc_idx];
	assign p_pend    = pending_q[proc_idx];
	assign p_blocked = (p_ext < 32'd16) && blk_q[p_ext[3:0]];
	assign fire      = cmd.proc && p_act && !p_pend && (r_new == '0) && !p_blocked
		&& (32'(fire_cnt_q) < ctt_pkg::MAX_FIRES);

	// count memory port select
	assign mem_we = (cmd.scan && slot_free) || (cmd.proc && p_act);
	assign mem_wa = cmd.scan ? idx : proc_idx;
	assign mem_wd = cmd.scan ? dur_q : r_new;

	// count memory
	always_ff @(posedge clk) begin
		if (mem_we)
			remaining_ms[mem_wa] <= mem_wd;
		if (cmd.rd)
			rdata_s1 <= remaining_ms[idx];
	end

	// operand latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dur_q <= dur_sat[COUNT_BITS-1:0];
			el_q  <= elapsed;
			blk_q <= blocked_mask;
		end
		if (fire)
			hold_slot_q <= proc_idx;
	end

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			pending_q <= '0;
		end else begin
			if (cmd.cancel && sel_ok && active_q[sel_i])
				pending_q[sel_i] <= 1'b1;
			if (cmd.scan && slot_free) begin
				active_q[idx]  <= 1'b1;
				pending_q[idx] <= 1'b0;
			end
			if (cmd.proc && p_act) begin
				if (p_pend) begin
					active_q[proc_idx]  <= 1'b0;
					pending_q[proc_idx] <= 1'b0;
				end else if (fire) begin
					active_q[proc_idx] <= 1'b0;
				end
			end
		end
	end

	// held firing and firing count of the current tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			fire_cnt_q <= '0;
		end else if (cmd.load) begin
			hold_vld_q <= 1'b0;
			fire_cnt_q <= '0;
		end else if (fire) begin
			hold_vld_q <= 1'b1;
			fire_cnt_q <= fire_cnt_q + ctt_pkg::FIRE_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.cancel || (cmd.scan && (slot_free || cmd.last_slot))
				|| (fire && hold_vld_q) || cmd.flush;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.cancel) begin
			event_q <= ctt_pkg::EV_CANCEL;
			slot_q  <= timer_slot;
			last_q  <= 1'b1;
		end else if (cmd.scan) begin
			event_q <= slot_free ? ctt_pkg::EV_STARTED : ctt_pkg::EV_FULL;
			slot_q  <= slot_free ? ctt_pkg::slot_low4(32'(idx)) : 4'd0;
			last_q  <= 1'b1;
		end else if (cmd.flush) begin
			event_q <= hold_vld_q ? ctt_pkg::EV_FIRED : ctt_pkg::EV_NONE;
			slot_q  <= hold_vld_q ? ctt_pkg::slot_low4(32'(hold_slot_q)) : 4'd0;
			last_q  <= 1'b1;
		end else if (fire) begin
			event_q <= ctt_pkg::EV_FIRED;
			slot_q  <= ctt_pkg::slot_low4(32'(hold_slot_q));
			last_q  <= 1'b0;
		end
	end

	assign strobe    = strobe_q;
	assign event_res = event_q;
	assign slot      = slot_q;
	assign last      = last_q;

endmodule

>>> rtl/ctt_checker.sv
// ----------------------------------------------------------------------------
// ctt_checker: port-level checks for the countdown timer table
// Watches the transaction ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ctt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  operation,
	input logic [3:0]  timer_slot,
	input logic        strobe,
	input logic [2:0]  event_res,
	input logic [3:0]  slot,
	input logic        last
);

	// a cancel is answered in the very next cycle with its own slot
	a_cancel_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == ctt_pkg::OP_CANCEL) |=>
		(strobe && event_res == ctt_pkg::EV_CANCEL && last
			&& slot == $past(timer_slot)))
		else $error("cancel not answered in the next cycle");

	// the final result of a transaction shows with the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("final result while busy");

	// only firings can be non-final, and more results are still to come
	a_mid_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> (busy && event_res == ctt_pkg::EV_FIRED))
		else $error("non-final result outside a tick sweep");

	// start and tick occupy the block with no result in the next cycle
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == ctt_pkg::OP_START
			|| operation == ctt_pkg::OP_TICK)) |=> (busy && !strobe))
		else $error("sweep did not take the block");

endmodule

bind countdown_timer_table ctt_checker u_ctt_checker (.*);
